>>> hw/rtl/lef_pkg.sv
// Shared types and constants for the Laplacian edge filter.
package lef_pkg;

  // Field and register widths
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_W        = 13;
  localparam int unsigned CFG_IDX_W    = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd256;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd256;

  // Clamp limits of the result
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  // Input beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             drain;
  } lef_in_t;

  // Output beat
  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } lef_out_t;

  // Window cell control: shift enable and load-from-side select
  typedef struct packed {
    logic en;
    logic load;
  } cell_ctl_t;

endpackage

>>> hw/rtl/lef_line_mem.sv
// Two-bank line store with registered reads; unwritten columns read as zero.
module lef_line_mem #(
  parameter int unsigned COL_W = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      a_bank_i,
  input  logic [COL_W:0]            a_col_i,
  input  logic                      b_bank_i,
  input  logic [COL_W:0]            b_col_i,
  input  logic                      w_bank_i,
  input  logic [COL_W-1:0]          w_col_i,
  input  logic [lef_pkg::PIX_W-1:0] w_data_i,
  output logic [lef_pkg::PIX_W-1:0] a_data_o,
  output logic [lef_pkg::PIX_W-1:0] b_data_o
);

  localparam int unsigned DEPTH = 2 ** (COL_W + 1);

  logic [lef_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [COL_W:0]            fill_q [2];
  logic [COL_W:0]            fill_d [2];
  logic [COL_W:0]            w_next;
  logic [lef_pkg::PIX_W-1:0] a_q;
  logic [lef_pkg::PIX_W-1:0] b_q;

  // Each bank is written as a prefix from column zero: track its length
  assign w_next = {1'b0, w_col_i} + (COL_W+1)'(1);

  always_comb begin
    fill_d = fill_q;
    if (en_i && (w_next > fill_q[w_bank_i])) begin
      fill_d[w_bank_i] = w_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q[0] <= '0;
      fill_q[1] <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Storage: reads see the value before this cycle's write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= (a_col_i >= fill_q[a_bank_i]) ? '0 :
             mem_q[{a_bank_i, a_col_i[COL_W-1:0]}];
      b_q <= (b_col_i >= fill_q[b_bank_i]) ? '0 :
             mem_q[{b_bank_i, b_col_i[COL_W-1:0]}];
      mem_q[{w_bank_i, w_col_i}] <= w_data_i;
    end
  end

  assign a_data_o = a_q;
  assign b_data_o = b_q;

endmodule

>>> hw/rtl/lef_win_cell.sv
// One pixel cell of the 3-wide window: shifts from its neighbor or loads.
module lef_win_cell (
  input  logic                      clk_i,
  input  lef_pkg::cell_ctl_t        ctl_i,
  input  logic [lef_pkg::PIX_W-1:0] nbr_i,
  input  logic [lef_pkg::PIX_W-1:0] load_i,
  output logic [lef_pkg::PIX_W-1:0] pix_o,
  output logic [lef_pkg::PIX_W-1:0] nxt_o
);

  logic [lef_pkg::PIX_W-1:0] pix_q;
  logic [lef_pkg::PIX_W-1:0] pix_d;

  always_comb begin
    pix_d = pix_q;
    if (ctl_i.en) begin
      pix_d = ctl_i.load ? load_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign pix_o = pix_q;
  assign nxt_o = pix_d;

endmodule

>>> hw/rtl/laplacian_edge_filter_unit.sv
// Top level of the streaming 4-neighbor Laplacian edge filter.
//
//  channel | direction | handshake                | beat
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | lef_in_t: pixel_value, drain
//  out     | output    | out_valid_o / out_stall_i| lef_out_t: edge_value, frame_last
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while the output is not stalled; a result passes the
// middle stage (line store read), then the window cells and output register.
// Reset clears counters, valids and the line store fill marks; no clearing pass.
// out_stall_i freezes the output register; the middle stage keeps moving while
// the output register is empty or being taken, so in_stall_o rises only when
// both stages are full and the output is stalled.
module laplacian_edge_filter_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lef_pkg::lef_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lef_pkg::lef_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [lef_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lef_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned EW    = COL_W + 1;
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW    = lef_pkg::PIX_W;

  // Configuration registers
  logic [lef_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [lef_pkg::HEIGHT_REG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lef_pkg::RESET_WIDTH;
      height_q <= lef_pkg::RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lef_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[lef_pkg::WIDTH_REG_W-1:0];
        end
        lef_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[lef_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective frame size, clamped to the supported range
  logic [EW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    priority if (width_q < lef_pkg::WIDTH_REG_W'(3)) begin
      w_eff = EW'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_q);
    end
    priority if (height_q < lef_pkg::HEIGHT_REG_W'(3)) begin
      h_eff = ROW_W'(3);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_q);
    end
  end

  // Handshake and stage advance
  logic out_valid_q;
  logic v1_q;
  logic adv;
  logic s1_go;
  logic s1_load_en;
  logic accept;

  assign adv        = !out_valid_q || !out_stall_i;
  assign s1_go      = v1_q && adv;
  assign s1_load_en = !v1_q || adv;
  assign in_stall_o = !s1_load_en;
  assign accept     = in_valid_i && s1_load_en;

  // Position counters
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic             drain_mode;
  logic             pix_item;
  logic             drn_item;
  logic             col_last;
  logic             drn_last;
  logic             border;

  assign drain_mode = in_row_q >= h_eff;
  assign pix_item   = accept && !drain_mode && !in_data_i.drain;
  assign drn_item   = accept && drain_mode && in_data_i.drain;
  assign col_last   = ({1'b0, in_col_q} + EW'(1)) >= w_eff;
  assign drn_last   = ({1'b0, out_col_q} + EW'(1)) >= w_eff;
  assign border     = (in_row_q == ROW_W'(1)) || (in_col_q == '0) || col_last;

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_col_d = out_col_q;
    priority if (drn_item) begin
      if (drn_last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_col_d = '0;
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end else if (pix_item) begin
      if (col_last) begin
        in_col_d  = '0;
        in_row_d  = in_row_q + ROW_W'(1);
        out_col_d = '0;
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_col_q <= out_col_d;
    end
  end

  // Line store: A reads the row above at the next column, B reads the row two
  // above at this column, or the row above at column zero when a row starts
  logic          first_col;
  logic          b_bank;
  logic [EW-1:0] b_col;
  logic [PW-1:0] rd_a;
  logic [PW-1:0] rd_b;

  assign first_col = (in_col_q == '0);
  assign b_bank    = first_col ? ~in_row_q[0] : in_row_q[0];
  assign b_col     = first_col ? '0 : {1'b0, in_col_q};

  lef_line_mem #(
    .COL_W (COL_W)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pix_item),
    .a_bank_i (~in_row_q[0]),
    .a_col_i  ({1'b0, in_col_q} + EW'(1)),
    .b_bank_i (b_bank),
    .b_col_i  (b_col),
    .w_bank_i (in_row_q[0]),
    .w_col_i  (in_col_q),
    .w_data_i (in_data_i.pixel_value),
    .a_data_o (rd_a),
    .b_data_o (rd_b)
  );

  // Middle stage: beat flags next to the line store read data
  logic          s1_pix_q;
  logic          s1_res_q;
  logic          s1_border_q;
  logic          s1_first_q;
  logic          s1_last_q;
  logic [PW-1:0] s1_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_load_en) begin
      v1_q <= pix_item || drn_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q    <= pix_item;
      s1_res_q    <= drn_item || (in_row_q != '0);
      s1_border_q <= drn_item || border;
      s1_first_q  <= first_col;
      s1_last_q   <= drn_item && drn_last;
      s1_down_q   <= in_data_i.pixel_value;
    end
  end

  // Window cells: right takes the row-above read, center takes its neighbor
  // or the column-zero read at a row start, left takes the center
  lef_pkg::cell_ctl_t ctl_r, ctl_c, ctl_l;
  logic [PW-1:0]      win_r, win_c, win_l;
  logic [PW-1:0]      nxt_r, nxt_c, nxt_l;

  assign ctl_r = '{en: s1_go && s1_pix_q, load: 1'b1};
  assign ctl_c = '{en: s1_go && s1_pix_q, load: s1_first_q};
  assign ctl_l = '{en: s1_go && s1_pix_q, load: 1'b0};

  lef_win_cell u_cell_r (
    .clk_i  (clk_i),
    .ctl_i  (ctl_r),
    .nbr_i  (rd_a),
    .load_i (rd_a),
    .pix_o  (win_r),
    .nxt_o  (nxt_r)
  );

  lef_win_cell u_cell_c (
    .clk_i  (clk_i),
    .ctl_i  (ctl_c),
    .nbr_i  (win_r),
    .load_i (rd_b),
    .pix_o  (win_c),
    .nxt_o  (nxt_c)
  );

  lef_win_cell u_cell_l (
    .clk_i  (clk_i),
    .ctl_i  (ctl_l),
    .nbr_i  (win_c),
    .load_i (rd_b),
    .pix_o  (win_l),
    .nxt_o  (nxt_l)
  );

  // Laplacian and clamp
  logic        [11:0] nbr_sum;
  logic        [11:0] ctr_x4;
  logic signed [11:0] lap;
  logic        [PW-1:0] lap_clamp;

  assign nbr_sum = 12'(nxt_l) + 12'(nxt_r) + 12'(rd_b) + 12'(s1_down_q);
  assign ctr_x4  = {2'b00, nxt_c, 2'b00};
  assign lap     = $signed(nbr_sum) - $signed(ctr_x4);

  always_comb begin
    priority if (lap < 12'sd0) begin
      lap_clamp = lef_pkg::PIX_MIN;
    end else if (lap > $signed({4'b0000, lef_pkg::PIX_MAX})) begin
      lap_clamp = lef_pkg::PIX_MAX;
    end else begin
      lap_clamp = lap[PW-1:0];
    end
  end

  // Output register
  lef_pkg::lef_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_go && s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.edge_value <= s1_border_q ? lef_pkg::PIX_MIN : lap_clamp;
      out_q.frame_last <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_last |-> out_data_o.edge_value == lef_pkg::PIX_MIN)
    else $error("frame_last beat carries a nonzero edge value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && out_valid_q && out_stall_i)
    else $error("input stalled without a full pipeline");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !adv |=> v1_q && $stable(s1_res_q) && $stable(s1_last_q))
    else $error("middle stage beat lost while output stalled");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_row_q) <= MAX_HEIGHT)
    else $error("row counter beyond frame height limit");

  a_left_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_pix_q |=> win_l === $past(win_c))
    else $error("left window cell missed its shift");

endmodule

>>> tb/testbench.sv
// Self-checking bench for the 4-neighbor Laplacian edge filter, with its own line-buffer predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 4096;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          WATCHDOG      = 2000;
  localparam int          RANDOM_BEATS  = 800;
  localparam int          CW            = lef_pkg::CFG_W;

  // Predicts each edge beat from a private line store and checks the output in order
  class laplace_scoreboard;
    bit [lef_pkg::PIX_W-1:0]        line_mem [2*MAX_W];
    int unsigned                    row_in, col_in, col_out;
    bit [lef_pkg::WIDTH_REG_W-1:0]  width_reg;
    bit [lef_pkg::HEIGHT_REG_W-1:0] height_reg;
    lef_pkg::lef_out_t              edge_q[$];
    int unsigned                    errors, frames_done, beats_used;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      row_in     = 0;
      col_in     = 0;
      col_out    = 0;
      width_reg  = lef_pkg::RESET_WIDTH;
      height_reg = lef_pkg::RESET_HEIGHT;
      errors     = 0;
      frames_done = 0;
      beats_used = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > MAX_H) h = MAX_H;
      return h;
    endfunction

    function void write_reg(logic [lef_pkg::CFG_IDX_W-1:0] idx,
                            logic [lef_pkg::CFG_W-1:0] data);
      if (idx == lef_pkg::REG_IMAGE_WIDTH) width_reg = data[lef_pkg::WIDTH_REG_W-1:0];
      else height_reg = data[lef_pkg::HEIGHT_REG_W-1:0];
    endfunction

    // Row r lives in bank r mod 2; columns past the store read as zero
    function int pix_at(int unsigned row, int unsigned col);
      if (col >= MAX_W) return 0;
      return int'(line_mem[(row % 2) * MAX_W + col]);
    endfunction

    function void take_beat(lef_pkg::lef_in_t b);
      int unsigned       w, h, c, r, rr;
      int                s;
      lef_pkg::lef_out_t e;
      w = eff_width();
      h = eff_height();
      // Drain phase: last row is border, only drain beats count
      if (row_in >= h) begin
        if (!b.drain) return;
        beats_used++;
        e.edge_value = lef_pkg::PIX_MIN;
        e.frame_last = (col_out + 1 >= w);
        edge_q.push_back(e);
        if (e.frame_last) begin
          row_in  = 0;
          col_in  = 0;
          col_out = 0;
          frames_done++;
        end else begin
          col_out++;
        end
        return;
      end
      if (b.drain) return;
      beats_used++;
      c = col_in;
      r = row_in;
      // Pixel (r-1, c) completes once its lower neighbor arrives
      if (r >= 1) begin
        rr = r - 1;
        s  = 0;
        if (!(rr == 0 || c == 0 || rr + 1 >= h || c + 1 >= w)) begin
          s = pix_at(rr, c - 1) + pix_at(rr, c + 1) + pix_at(r, c)
            + int'(b.pixel_value) - 4 * pix_at(rr, c);
          if (s < 0) s = 0;
          if (s > 255) s = 255;
        end
        e.edge_value = s[lef_pkg::PIX_W-1:0];
        e.frame_last = 1'b0;
        edge_q.push_back(e);
      end
      if (c < MAX_W) line_mem[(r % 2) * MAX_W + c] = b.pixel_value;
      if (c + 1 >= w) begin
        col_in  = 0;
        row_in  = r + 1;
        col_out = 0;
      end else begin
        col_in = c + 1;
      end
    endfunction

    function void check_beat(lef_pkg::lef_out_t got);
      lef_pkg::lef_out_t e;
      if (edge_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual edge_value %0d frame_last %0d",
                 $time, got.edge_value, got.frame_last);
        errors++;
        return;
      end
      e = edge_q.pop_front();
      if (got.edge_value !== e.edge_value) begin
        $display("%0t: edge_value mismatch: expected %0d, actual %0d",
                 $time, e.edge_value, got.edge_value);
        errors++;
      end
      if (got.frame_last !== e.frame_last) begin
        $display("%0t: frame_last mismatch: expected %0d, actual %0d",
                 $time, e.frame_last, got.frame_last);
        errors++;
      end
    endfunction

    function int pending();
      return edge_q.size();
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  lef_pkg::lef_in_t              in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  lef_pkg::lef_out_t             out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [lef_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [lef_pkg::CFG_W-1:0]     cfg_data_i  = '0;

  laplace_scoreboard sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  laplacian_edge_filter_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(out_data_o);
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input bit drain, input bit [lef_pkg::PIX_W-1:0] pix);
    lef_pkg::lef_in_t b;
    b.pixel_value = pix;
    b.drain       = drain;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_beat(b);
  endtask

  task automatic write_reg(input logic [lef_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lef_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop sending, let every expected beat out, then let the pipe settle
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly small frames, some below the legal minimum, a few wider/taller
  task automatic write_random_config();
    int sel;
    sel = $urandom_range(9);
    if ($urandom_range(99) < 80) begin
      if (sel == 0) write_reg(lef_pkg::REG_IMAGE_WIDTH, CW'($urandom_range(2)));
      else if (sel == 1) write_reg(lef_pkg::REG_IMAGE_WIDTH, CW'($urandom_range(40, 13)));
      else write_reg(lef_pkg::REG_IMAGE_WIDTH, CW'($urandom_range(12, 3)));
    end
    sel = $urandom_range(9);
    if ($urandom_range(99) < 60) begin
      if (sel == 0) write_reg(lef_pkg::REG_IMAGE_HEIGHT, CW'($urandom_range(2)));
      else if (sel == 1) write_reg(lef_pkg::REG_IMAGE_HEIGHT, CW'($urandom_range(16, 9)));
      else write_reg(lef_pkg::REG_IMAGE_HEIGHT, CW'($urandom_range(8, 3)));
    end
  endtask

  function automatic bit [lef_pkg::PIX_W-1:0] pick_pixel(int mode,
                                                         bit [lef_pkg::PIX_W-1:0] base);
    int v;
    case (mode)
      1: return $urandom_range(1) ? lef_pkg::PIX_MAX : lef_pkg::PIX_MIN;
      2: begin
        v = int'(base) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[lef_pkg::PIX_W-1:0];
      end
      3: return ($urandom_range(9) == 0) ? lef_pkg::PIX_MAX : lef_pkg::PIX_MIN;
      default: begin
        v = int'($urandom_range(255));
        return v[lef_pkg::PIX_W-1:0];
      end
    endcase
  endfunction

  // Runs the current frame to its last drain beat; noise sends the wrong kind of
  // beat, pause_at rewrites the registers mid-frame once everything is out
  task automatic send_frame(input int noise_pct, input int pause_at, input int mode);
    int unsigned              start;
    int                       sent;
    bit [lef_pkg::PIX_W-1:0]  base;
    bit                       drain;
    start = sb.frames_done;
    sent  = 0;
    base  = pick_pixel(0, '0);
    while (sb.frames_done == start) begin
      if (sent == pause_at) begin
        wait_quiet();
        write_random_config();
      end
      drain = (sb.row_in >= sb.eff_height());
      if ($urandom_range(99) < noise_pct) drain = !drain;
      send_item(drain, pick_pixel(mode, base));
      sent++;
    end
  endtask

  initial begin
    int          i;
    int          frame_no;
    int unsigned target;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: checkerboard, centre 0 under four 255 neighbors clamps high
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    for (i = 0; i < 9; i++) begin
      if (i == 4) send_item(1'b1, lef_pkg::PIX_MAX);   // drain while pixels expected: ignored
      send_item(1'b0, ((sb.row_in + sb.col_in) % 2) ? lef_pkg::PIX_MAX : lef_pkg::PIX_MIN);
    end
    send_item(1'b0, 8'hAA);                   // pixel while draining: ignored
    repeat (3) send_item(1'b1, lef_pkg::PIX_MIN);
    wait_quiet();

    // Directed: lone bright centre clamps low; width shrinks mid-frame below minimum
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 4);
    for (i = 0; i < 6; i++) begin
      send_item(1'b0, (sb.row_in == 1 && sb.col_in == 1) ? lef_pkg::PIX_MAX : lef_pkg::PIX_MIN);
    end
    wait_quiet();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 1);
    send_frame(0, -1, 0);
    wait_quiet();

    // Back-pressure: receiver holds off while the sender streams without gaps
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 6);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 5);
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq++;
    send_frame(0, -1, 0);
    wait_quiet();

    // Random frames across the idling mixes
    target   = sb.beats_used + RANDOM_BEATS;
    frame_no = 0;
    while (sb.beats_used < target) begin
      wait_quiet();
      write_random_config();
      case (frame_no % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      send_frame(($urandom_range(3) == 0) ? 5 : 0,
                 ($urandom_range(5) == 0) ? int'($urandom_range(30, 1)) : -1,
                 $urandom_range(3));
      frame_no++;
    end

    // Extremes: oversized width register, row cut short by a narrower width
    wait_quiet();
    idle_pct  = 33;
    stall_pct = 33;
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 2047);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 0);
    for (i = 0; i < 40; i++) send_item(1'b0, pick_pixel(0, '0));
    wait_quiet();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 5);
    send_frame(0, -1, 0);
    wait_quiet();

    // Extremes: oversized height register, frame cut short by a lower height
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 8191);
    for (i = 0; i < 18; i++) send_item(1'b0, pick_pixel(3, '0));
    wait_quiet();
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    send_frame(0, -1, 3);

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
